// ===== hw/rtl/tracker_pattern_cell_unpacker_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the pattern cell unpacker
// Concurrent checks that compile away in synthesis builds.
// ----------------------------------------------------------------------------
`ifndef TRACKER_PATTERN_CELL_UNPACKER_MACROS_SVH
`define TRACKER_PATTERN_CELL_UNPACKER_MACROS_SVH

`ifndef SYNTHESIS
// The property must hold at every clock edge outside reset.
`define TPCU_ASSERT(label, clk, rst_n, prop) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
		else $error("tpcu assertion failed");
// The condition must never be true at a clock edge outside reset.
`define TPCU_ASSERT_NEVER(label, clk, rst_n, cond) \
	label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
		else $error("tpcu forbidden condition seen");
`else
`define TPCU_ASSERT(label, clk, rst_n, prop)
`define TPCU_ASSERT_NEVER(label, clk, rst_n, cond)
`endif

`endif

// ===== hw/rtl/tpcu_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tpcu_pkg
// Shared types and constants of the pattern cell unpacker.
// ----------------------------------------------------------------------------
package tpcu_pkg;

	localparam int MAX_CHANNELS = 64;
	localparam int CH_W         = 6;
	localparam int ROW_W        = 8;
	localparam int CNT_W        = 7;

	localparam logic [4:0] FULL_MASK       = 5'h1F;
	localparam logic [4:0] NOTE_BYTE_MASK  = 5'h1E;
	localparam logic [7:0] EXT_EFFECT      = 8'h0E;
	localparam logic [7:0] EXT_EFFECT_BASE = 8'd36;
	localparam logic [3:0] NIBBLE_MASK     = 4'hF;

	localparam logic [CNT_W-1:0] CHANNEL_COUNT_RESET = 7'd8;

	// Register indexes of the configuration port.
	localparam logic REG_CHANNEL_COUNT = 1'b0;

	// Index of the parameter field; positions at or past it close the cell.
	localparam logic [2:0] PARAM_FIELD = 3'd4;

	typedef struct packed {
		logic       restart;
		logic [7:0] note;
		logic [7:0] instrument;
		logic [7:0] volume;
		logic [7:0] effect;
		logic [7:0] param;
	} cell_t;

	function automatic logic [2:0] lowest_index(input logic [4:0] mask);
		logic [2:0] idx;
		idx = 3'd0;
		for (int i = 4; i >= 0; i--) begin
			if (mask[i]) begin
				idx = 3'(i);
			end
		end
		return idx;
	endfunction

endpackage

// ===== hw/rtl/tracker_pattern_cell_unpacker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tracker_pattern_cell_unpacker
// Unpacks packed pattern bytes into cells tagged with channel and row.
// ----------------------------------------------------------------------------
// Throughput: one byte per cycle while the queue is not full; at most one cell
// beat per cycle leaves, held while out_stall is high. The assembler pushes a
// cell into the two-entry queue when its last byte is taken; the output register
// takes it from the queue head. The input stalls only while the queue is full.
// Reset: asynchronous; counters, masks and queue clear, and the channel
// count returns to 8.
module tracker_pattern_cell_unpacker import tpcu_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             psel,
	input  logic             penable,
	input  logic             pwrite,
	input  logic [2:0]       paddr,
	input  logic [31:0]      pwdata,
	output logic [31:0]      prdata,
	output logic             pready,
	input  logic             in_valid,
	output logic             in_stall,
	input  logic [7:0]       packed_byte,
	input  logic             pattern_start,
	output logic             out_valid,
	input  logic             out_stall,
	output logic [7:0]       note,
	output logic [7:0]       instrument,
	output logic [7:0]       volume,
	output logic [7:0]       effect,
	output logic [7:0]       parameter_res,
	output logic [CH_W-1:0]  channel,
	output logic [ROW_W-1:0] row
);

	logic [CNT_W-1:0] channel_count_q;
	logic             push, pop, head_valid, q_full;
	cell_t            push_cell, head_cell;

	assign pready   = 1'b1;
	assign in_stall = q_full;
	assign prdata   = (paddr[2] == REG_CHANNEL_COUNT) ? {25'd0, channel_count_q} : 32'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			channel_count_q <= CHANNEL_COUNT_RESET;
		end else if (psel && penable && pwrite && pready
				&& paddr[2] == REG_CHANNEL_COUNT) begin
			channel_count_q <= pwdata[CNT_W-1:0];
		end
	end

	tpcu_front u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.packed_byte   (packed_byte),
		.pattern_start (pattern_start),
		.q_full        (q_full),
		.push          (push),
		.asm_cell      (push_cell)
	);

	tpcu_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_cell  (push_cell),
		.pop        (pop),
		.head_valid (head_valid),
		.head_cell  (head_cell),
		.full       (q_full)
	);

	tpcu_back u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.channel_count (channel_count_q),
		.head_valid    (head_valid),
		.head_cell     (head_cell),
		.pop           (pop),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.note          (note),
		.instrument    (instrument),
		.volume        (volume),
		.effect        (effect),
		.parameter_res (parameter_res),
		.channel       (channel),
		.row           (row)
	);

endmodule

// ===== hw/rtl/tpcu_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tpcu_front
// Accepts packed bytes, tracks the presence mask and assembles cells.
// ----------------------------------------------------------------------------
`include "tracker_pattern_cell_unpacker_macros.svh"
module tpcu_front import tpcu_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	input  logic [7:0] packed_byte,
	input  logic       pattern_start,
	input  logic       q_full,
	output logic       push,
	output cell_t      asm_cell
);

	logic [2:0]  pos_q, pos_d, pos_eff, idx;
	logic [4:0]  mask_q, mask_d, mask_eff, mask_new;
	logic [31:0] fields_q, fields_d, fields_eff, fields_new;
	logic        restart_q, restart_d, restart_eff;
	logic        accept;

	always_comb begin
		accept      = in_valid && !q_full;
		pos_eff     = pattern_start ? 3'd0 : pos_q;
		mask_eff    = pattern_start ? 5'd0 : mask_q;
		fields_eff  = pattern_start ? 32'd0 : fields_q;
		restart_eff = pattern_start || restart_q;
		idx         = pos_eff - 3'd1;

		for (int k = 0; k < 4; k++) begin
			fields_new[8*k +: 8] = (idx[1:0] == 2'(k)) ? packed_byte : fields_eff[8*k +: 8];
		end
		mask_new = mask_eff & ~(5'(5'b1 << idx[1:0]));

		pos_d     = pos_q;
		mask_d    = mask_q;
		fields_d  = fields_q;
		restart_d = restart_q;
		push      = 1'b0;
		asm_cell  = '{restart: restart_eff, note: fields_eff[7:0],
			instrument: fields_eff[15:8], volume: fields_eff[23:16],
			effect: fields_eff[31:24], param: 8'd0};

		if (accept) begin
			restart_d = restart_eff;
			if (pos_eff == 3'd0) begin
				if (packed_byte[7]) begin
					if ((packed_byte[4:0] & FULL_MASK) == 5'd0) begin
						// A mask with no fields is an empty cell, emitted at once.
						push = 1'b1;
						asm_cell.note       = 8'd0;
						asm_cell.instrument = 8'd0;
						asm_cell.volume     = 8'd0;
						asm_cell.effect     = 8'd0;
						pos_d    = 3'd0;
						mask_d   = 5'd0;
						fields_d = 32'd0;
					end else begin
						mask_d   = packed_byte[4:0];
						fields_d = 32'd0;
						pos_d    = lowest_index(packed_byte[4:0]) + 3'd1;
					end
				end else begin
					// A plain byte is the note of a full cell.
					fields_d = {24'd0, packed_byte};
					mask_d   = NOTE_BYTE_MASK;
					pos_d    = 3'd2;
				end
			end else if (idx >= PARAM_FIELD) begin
				push           = 1'b1;
				asm_cell.param = packed_byte;
				pos_d    = 3'd0;
				mask_d   = 5'd0;
				fields_d = 32'd0;
			end else if (mask_new == 5'd0) begin
				push                = 1'b1;
				asm_cell.note       = fields_new[7:0];
				asm_cell.instrument = fields_new[15:8];
				asm_cell.volume     = fields_new[23:16];
				asm_cell.effect     = fields_new[31:24];
				pos_d    = 3'd0;
				mask_d   = 5'd0;
				fields_d = 32'd0;
			end else begin
				fields_d = fields_new;
				mask_d   = mask_new;
				pos_d    = lowest_index(mask_new) + 3'd1;
			end
			if (push) begin
				restart_d = 1'b0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q     <= 3'd0;
			mask_q    <= 5'd0;
			fields_q  <= 32'd0;
			restart_q <= 1'b0;
		end else begin
			pos_q     <= pos_d;
			mask_q    <= mask_d;
			fields_q  <= fields_d;
			restart_q <= restart_d;
		end
	end

	// An open cell always has at least one field still awaited.
	`TPCU_ASSERT(a_pos_matches_mask, clk, arst_n, (pos_q != 3'd0) == (mask_q != 5'd0))
	`TPCU_ASSERT_NEVER(a_push_when_full, clk, arst_n, push && q_full)

endmodule

// ===== hw/rtl/tpcu_queue.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tpcu_queue
// Two-entry queue of assembled cells between the front and back parts.
// ----------------------------------------------------------------------------
`include "tracker_pattern_cell_unpacker_macros.svh"
module tpcu_queue import tpcu_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  push,
	input  cell_t push_cell,
	input  logic  pop,
	output logic  head_valid,
	output cell_t head_cell,
	output logic  full
);

	cell_t      entry_q [2];
	logic       wr_ptr_q, rd_ptr_q;
	logic [1:0] count_q;

	assign head_valid = (count_q != 2'd0);
	assign full       = (count_q == 2'd2);
	assign head_cell  = entry_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_cell;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			count_q <= count_q + 2'(push) - 2'(pop);
		end
	end

	`TPCU_ASSERT(a_count_bounded, clk, arst_n, count_q <= 2'd2)
	`TPCU_ASSERT_NEVER(a_pop_empty, clk, arst_n, pop && !head_valid)

endmodule

// ===== hw/rtl/tpcu_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tpcu_back
// Remaps extended effects, tags cells with channel and row, holds the result.
// ----------------------------------------------------------------------------
`include "tracker_pattern_cell_unpacker_macros.svh"
module tpcu_back import tpcu_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic [CNT_W-1:0] channel_count,
	input  logic             head_valid,
	input  cell_t            head_cell,
	output logic             pop,
	output logic             out_valid,
	input  logic             out_stall,
	output logic [7:0]       note,
	output logic [7:0]       instrument,
	output logic [7:0]       volume,
	output logic [7:0]       effect,
	output logic [7:0]       parameter_res,
	output logic [CH_W-1:0]  channel,
	output logic [ROW_W-1:0] row
);

	logic [CH_W-1:0]  chan_q, chan_cur;
	logic [ROW_W-1:0] row_q, row_cur;
	logic [CNT_W-1:0] count_eff, chan_next;
	logic [7:0]       eff_out, param_out;
	logic             valid_q;

	assign pop       = head_valid && (!valid_q || !out_stall);
	assign out_valid = valid_q;

	always_comb begin
		// A pattern start ahead of this cell sends it to channel 0 of row 0.
		chan_cur = head_cell.restart ? '0 : chan_q;
		row_cur  = head_cell.restart ? '0 : row_q;

		if (channel_count == '0) begin
			count_eff = CNT_W'(1);
		end else if (channel_count > CNT_W'(MAX_CHANNELS)) begin
			count_eff = CNT_W'(MAX_CHANNELS);
		end else begin
			count_eff = channel_count;
		end
		chan_next = {1'b0, chan_cur} + CNT_W'(1);

		if (head_cell.effect == EXT_EFFECT) begin
			eff_out   = EXT_EFFECT_BASE + {4'd0, head_cell.param[7:4]};
			param_out = {4'd0, head_cell.param[3:0] & NIBBLE_MASK};
		end else begin
			eff_out   = head_cell.effect;
			param_out = head_cell.param;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			note          <= head_cell.note;
			instrument    <= head_cell.instrument;
			volume        <= head_cell.volume;
			effect        <= eff_out;
			parameter_res <= param_out;
			channel       <= chan_cur;
			row           <= row_cur;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			chan_q  <= '0;
			row_q   <= '0;
		end else begin
			if (pop) begin
				valid_q <= 1'b1;
			end else if (!out_stall) begin
				valid_q <= 1'b0;
			end
			if (pop) begin
				// The row counter is as wide as the row range, so it wraps by itself.
				if (chan_next >= count_eff) begin
					chan_q <= '0;
					row_q  <= row_cur + ROW_W'(1);
				end else begin
					chan_q <= chan_next[CH_W-1:0];
					row_q  <= row_cur;
				end
			end
		end
	end

	`TPCU_ASSERT(a_drain_clears, clk, arst_n,
		(valid_q && !out_stall && !pop) |=> !valid_q)

endmodule
